@@ src/eeprom_wear_level_record_locator_assert.svh @@
// Assertion macros for the wear-level record locator
`ifndef EEPROM_WEAR_LEVEL_RECORD_LOCATOR_ASSERT_SVH
`define EEPROM_WEAR_LEVEL_RECORD_LOCATOR_ASSERT_SVH
`ifndef SYNTH
`define EWL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define EWL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define EWL_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define EWL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ src/ewl_pkg.sv @@
`default_nettype none
package ewl_pkg;
	localparam int FILL_CHUNK_DEF = 16;
	localparam int ADDR_BITS_DEF  = 16;

	// register indexes
	localparam logic [2:0] REG_MEM_BYTES    = 3'd0;
	localparam logic [2:0] REG_DATA_OFFSET  = 3'd1;
	localparam logic [2:0] REG_RECORD_BYTES = 3'd2;
	localparam logic [2:0] REG_FLAG_ADDRESS = 3'd3;
	localparam logic [2:0] REG_FLAG_VALUE   = 3'd4;

	// func codes
	localparam logic [2:0] FN_STEP    = 3'd0;
	localparam logic [2:0] FN_LOAD    = 3'd1;
	localparam logic [2:0] FN_SAVE    = 3'd2;
	localparam logic [2:0] FN_CLEAR   = 3'd3;
	localparam logic [2:0] FN_RESTART = 3'd4;

	// memory op codes
	localparam logic [2:0] OP_NONE   = 3'd0;
	localparam logic [2:0] OP_RFLAG  = 3'd1;
	localparam logic [2:0] OP_RREC   = 3'd2;
	localparam logic [2:0] OP_FILL   = 3'd3;
	localparam logic [2:0] OP_WFLAG  = 3'd4;
	localparam logic [2:0] OP_WREC   = 3'd5;

	typedef enum logic [2:0] {
		PH_START, PH_INIT, PH_CLEAR, PH_WFLAG, PH_WFIRST, PH_WRITE, PH_READ, PH_IDLE
	} phase_t;

	typedef enum logic [3:0] {
		C_IDLE, C_CNT, C_EXEC, C_ADDR, C_PCT, C_OUT
	} ctl_state_t;

	// controller -> datapath
	typedef struct packed {
		logic cfg_we;
		logic accept;
		logic cnt_start;
		logic exec;
		logic addr_start;
		logic pct_start;
	} ewl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic mul_done;
	} ewl_sts_t;
endpackage
`default_nettype wire

@@ src/ewl_if.sv @@
`default_nettype none
interface ewl_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] func;
	logic       clear_defaults;
	logic [15:0] read_word;
	modport source (output valid, func, clear_defaults, read_word, input ready);
	modport sink (input valid, func, clear_defaults, read_word, output ready);
endinterface

interface ewl_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  mem_op;
	logic [15:0] mem_addr;
	logic        write_dir;
	logic [15:0] slot_index;
	logic        busy_res;
	logic [6:0]  progress;
	modport source (output valid, mem_op, mem_addr, write_dir, slot_index, busy_res,
		progress, input ready);
	modport sink (input valid, mem_op, mem_addr, write_dir, slot_index, busy_res,
		progress, output ready);
endinterface

interface ewl_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ src/ewl_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle
module ewl_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [23:0] dividend,
	input  wire logic [23:0] divisor,
	output logic [23:0]      quot,
	output logic             done
);
	logic [23:0] q_q;
	logic [24:0] r_q;
	logic [23:0] d_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic [24:0] trial;

	assign trial = {r_q[23:0], q_q[23]} - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 5'd24;
			end else if (run_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					run_q <= 1'b0;
					done  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			if (!trial[24]) begin
				r_q <= trial;
				q_q <= {q_q[22:0], 1'b1};
			end else begin
				r_q <= {r_q[23:0], q_q[23]};
				q_q <= {q_q[22:0], 1'b0};
			end
		end
	end

	assign quot = q_q;
endmodule
`default_nettype wire

@@ src/ewl_ctrl.sv @@
`default_nettype none
// Sequencing of one request: slot count, state update, address, percentage
module ewl_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	output ewl_pkg::ewl_cmd_t cmd,
	input  wire ewl_pkg::ewl_sts_t sts
);
	import ewl_pkg::*;
	`include "eeprom_wear_level_record_locator_assert.svh"

	ctl_state_t st_q, st_d;
	logic       ov_q, ov_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= C_IDLE;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			ov_q <= ov_d;
		end
	end

	always_comb begin
		st_d = st_q;
		ov_d = ov_q;
		cmd  = '0;
		in_ready  = 1'b0;
		cfg_ready = (st_q == C_IDLE) && !ov_q;
		cmd.cfg_we = cfg_valid && cfg_ready;
		if (ov_q && out_ready) ov_d = 1'b0;
		case (st_q)
			C_IDLE: begin
				in_ready = !ov_q && !cfg_valid;
				if (in_valid && in_ready) begin
					cmd.accept    = 1'b1;
					cmd.cnt_start = 1'b1;
					st_d = C_CNT;
				end
			end
			C_CNT: if (sts.div_done) begin
				cmd.exec = 1'b1;
				st_d = C_EXEC;
			end
			C_EXEC: begin
				cmd.addr_start = 1'b1;
				st_d = C_ADDR;
			end
			C_ADDR: if (sts.mul_done) begin
				cmd.pct_start = 1'b1;
				st_d = C_PCT;
			end
			C_PCT: if (sts.div_done) st_d = C_OUT;
			C_OUT: begin
				ov_d = 1'b1;
				st_d = C_IDLE;
			end
			default: st_d = C_IDLE;
		endcase
	end

	assign out_valid = ov_q;

	`EWL_ASSERT_IMPL(a_no_in_while_out, clk, arst_n, ov_q, !in_ready)
	`EWL_ASSERT_NEXT(a_accept_busy, clk, arst_n, cmd.accept, st_q == C_CNT)
	`EWL_ASSERT_IMPL(a_cfg_idle, clk, arst_n, cmd.cfg_we, st_q == C_IDLE)
endmodule
`default_nettype wire

@@ src/ewl_dp.sv @@
`default_nettype none
// Sequencer state, registers and arithmetic
module ewl_dp #(
	parameter int FILL_CHUNK = ewl_pkg::FILL_CHUNK_DEF,
	parameter int ADDR_BITS  = ewl_pkg::ADDR_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire ewl_pkg::ewl_cmd_t cmd,
	output ewl_pkg::ewl_sts_t sts,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [16:0] cfg_data,
	input  wire logic [2:0]  func,
	input  wire logic        clear_defaults,
	input  wire logic [15:0] read_word,
	output logic [2:0]  mem_op,
	output logic [15:0] mem_addr,
	output logic        write_dir,
	output logic [15:0] slot_index,
	output logic        busy_res,
	output logic [6:0]  progress
);
	import ewl_pkg::*;

	localparam logic [16:0] CHUNK = 17'(FILL_CHUNK);
	localparam logic [23:0] AMASK = 24'((32'd1 << ADDR_BITS) - 1);

	// configuration
	logic [16:0] mem_bytes_q;
	logic [15:0] data_offset_q, flag_address_q, flag_value_q;
	logic [7:0]  record_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_bytes_q    <= 17'd8192;
			data_offset_q  <= 16'd16;
			record_bytes_q <= 8'd18;
			flag_address_q <= 16'd0;
			flag_value_q   <= 16'd23205;
		end else if (cmd.cfg_we) begin
			case (cfg_index)
				REG_MEM_BYTES:    mem_bytes_q    <= cfg_data;
				REG_DATA_OFFSET:  data_offset_q  <= cfg_data[15:0];
				REG_RECORD_BYTES: record_bytes_q <= cfg_data[7:0];
				REG_FLAG_ADDRESS: flag_address_q <= cfg_data[15:0];
				REG_FLAG_VALUE:   flag_value_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	logic [7:0] rb;
	assign rb = (record_bytes_q == 8'd0) ? 8'd1 : record_bytes_q;

	// shared divider
	logic        div_start, div_done;
	logic [23:0] div_a, div_b, div_q;
	ewl_div u_div (.clk, .arst_n, .start(div_start), .dividend(div_a),
		.divisor(div_b), .quot(div_q), .done(div_done));

	// state
	phase_t      phase_q;
	logic        await_q, dir_q, rdir_q;
	logic [16:0] fill_q;
	logic [15:0] slot_q, low_q, mid_q, high_q, cnt_q;
	logic [2:0]  f_q;
	logic        cd_q;
	logic [15:0] rd_q;
	logic [2:0]  op_q;
	logic        wdir_q, sa_flag_q;
	logic [15:0] sa_pos_q, dir_addr_q;
	logic [2:0]  pmode_q;

	// percentage needs a division only while formatting or searching
	logic pct_run;
	assign pct_run = (phase_q == PH_CLEAR) || (phase_q == PH_READ);

	// slot count from the divider (at reset the default configuration gives 454)
	logic [15:0] cnt_now;
	always_comb begin
		if (div_q > 24'd65535) cnt_now = 16'hFFFF;
		else if (div_q == 24'd0) cnt_now = 16'd1;
		else cnt_now = div_q[15:0];
	end

	// search step helpers
	logic [16:0] sum_up, sum_dn;

	logic read_bit;
	assign read_bit = rd_q[0];
	logic        up;
	assign up = (dir_q == read_bit);

	// address multiply, four bits of the slot per cycle
	logic [23:0] acc_q;
	logic [15:0] mpos_q;
	logic [2:0]  mcnt_q;
	logic        mrun_q, mdone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q <= 1'b0; mdone_q <= 1'b0; mcnt_q <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.addr_start) begin
				mrun_q <= 1'b1; mcnt_q <= 3'd4;
			end else if (mrun_q) begin
				mcnt_q <= mcnt_q - 3'd1;
				if (mcnt_q == 3'd1) begin
					mrun_q <= 1'b0; mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_start) begin
			acc_q  <= '0;
			mpos_q <= sa_pos_q;
		end else if (mrun_q) begin
			acc_q  <= (acc_q << 4) + 24'(mpos_q[15:12] * rb);
			mpos_q <= {mpos_q[11:0], 4'd0};
		end
	end

	// percentage operands; total / 10 and total / 100 by reciprocal multiply
	logic [16:0] part_v, total_v;
	logic [23:0] pa, pt;
	logic [34:0] t10_p, t100_p;
	logic        pct_zero_q;
	logic [6:0]  pct_fix_q;
	logic        pct_skip_q;

	assign t10_p  = 35'(total_v) * 35'd104858;
	assign t100_p = 35'(total_v) * 35'd167773;

	always_comb begin
		part_v  = '0;
		total_v = '0;
		if (phase_q == PH_CLEAR) begin
			part_v = fill_q; total_v = mem_bytes_q;
		end else begin
			part_v  = {1'b0, cnt_q > ((high_q >= low_q) ? high_q - low_q : 16'd0)
				? cnt_q - ((high_q >= low_q) ? high_q - low_q : 16'd0) : 16'd0};
			total_v = {1'b0, cnt_q};
		end
		if (part_v <= 17'd655) begin
			pa = 24'(part_v) * 24'd100; pt = 24'(total_v);
		end else if (part_v <= 17'd6553) begin
			pa = 24'(part_v) * 24'd10; pt = {9'd0, t10_p[34:20]};
		end else begin
			pa = 24'(part_v); pt = {13'd0, t100_p[34:24]};
		end
	end

	assign div_start = cmd.cnt_start || (cmd.pct_start && pct_run);
	assign div_a = cmd.cnt_start
		? ((mem_bytes_q > {1'b0, data_offset_q}) ? 24'(mem_bytes_q - {1'b0, data_offset_q}) : 24'd0)
		: pa;
	assign div_b = cmd.cnt_start ? {16'd0, rb} : pt;

	// fixed percentage: report done in the cycle after the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pct_skip_q <= 1'b0;
		else pct_skip_q <= cmd.pct_start && !pct_run;
	end

	assign sts.div_done = div_done || pct_skip_q;
	assign sts.mul_done = mdone_q;

	// main state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			await_q <= 1'b0;
			fill_q  <= '0;
			slot_q  <= '0;
			low_q   <= '0;
			high_q  <= 16'd453;
			mid_q   <= 16'd227;
			dir_q   <= 1'b0;
			rdir_q  <= 1'b0;
			cnt_q   <= 16'd454;
			op_q    <= OP_NONE;
			wdir_q  <= 1'b0;
			sa_flag_q <= 1'b0;
			sa_pos_q  <= '0;
			f_q     <= FN_STEP;
			cd_q    <= 1'b0;
			rd_q    <= '0;
		end else if (cmd.accept) begin
			f_q <= func; cd_q <= clear_defaults; rd_q <= read_word;
		end else if (cmd.exec) begin
			cnt_q <= cnt_now;
			op_q <= OP_NONE; wdir_q <= 1'b0; sa_flag_q <= 1'b0; sa_pos_q <= '0;
			case (f_q)
				FN_LOAD: begin phase_q <= PH_INIT; await_q <= 1'b0; end
				FN_SAVE: begin phase_q <= PH_WRITE; await_q <= 1'b0; end
				FN_CLEAR: begin
					if (cd_q) begin dir_q <= 1'b0; rdir_q <= 1'b0; end
					fill_q <= '0; phase_q <= PH_CLEAR; await_q <= 1'b0;
				end
				FN_RESTART: begin phase_q <= PH_START; await_q <= 1'b0; end
				FN_STEP: begin
					if (await_q) begin
						await_q <= 1'b0;
						case (phase_q)
							PH_START: if (rd_q != flag_value_q) begin
								phase_q <= PH_CLEAR; fill_q <= '0;
							end else phase_q <= PH_INIT;
							PH_INIT: begin
								rdir_q <= read_bit; dir_q <= read_bit;
								low_q <= '0; high_q <= cnt_now - 16'd1;
								mid_q <= 16'((17'(cnt_now - 16'd1) + 17'd1) >> 1);
								phase_q <= PH_READ;
							end
							PH_READ: begin
								rdir_q <= read_bit;
								if (low_q == high_q) begin
									slot_q <= mid_q; phase_q <= PH_IDLE;
								end else if (mid_q == high_q && !up) begin
									mid_q <= low_q; high_q <= low_q;
								end else if (up) begin
									low_q <= mid_q;
									mid_q <= sum_up[16:1];
								end else begin
									high_q <= mid_q;
									mid_q <= sum_dn[16:1];
								end
							end
							default: ;
						endcase
					end else begin
						case (phase_q)
							PH_START: begin op_q <= OP_RFLAG; await_q <= 1'b1; end
							PH_INIT: begin
								op_q <= OP_RREC; sa_flag_q <= 1'b1; await_q <= 1'b1;
							end
							PH_READ: begin
								op_q <= OP_RREC; sa_flag_q <= 1'b1; sa_pos_q <= mid_q;
								await_q <= 1'b1;
							end
							PH_CLEAR: begin
								op_q <= OP_FILL;
								if (fill_q + CHUNK >= mem_bytes_q || fill_q + CHUNK < fill_q)
									phase_q <= PH_WFLAG;
								fill_q <= fill_q + CHUNK;
							end
							PH_WFLAG: begin op_q <= OP_WFLAG; phase_q <= PH_WFIRST; end
							PH_WFIRST: begin
								rdir_q <= 1'b0; dir_q <= 1'b0; slot_q <= '0;
								op_q <= OP_WREC; sa_flag_q <= 1'b1; phase_q <= PH_IDLE;
							end
							PH_WRITE: begin
								if (slot_q >= cnt_now - 16'd1) begin
									slot_q <= '0; dir_q <= ~dir_q; rdir_q <= ~dir_q;
									wdir_q <= ~dir_q; sa_pos_q <= '0;
								end else begin
									slot_q <= slot_q + 16'd1; rdir_q <= dir_q;
									wdir_q <= dir_q; sa_pos_q <= slot_q + 16'd1;
								end
								op_q <= OP_WREC; sa_flag_q <= 1'b1; phase_q <= PH_IDLE;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	assign sum_up = ({1'b0, mid_q} + {1'b0, high_q} + 17'd1);
	assign sum_dn = ({1'b0, low_q} + {1'b0, mid_q});

	// address of the request after the multiply
	always_ff @(posedge clk) begin
		if (mdone_q) begin
			case (op_q)
				OP_RFLAG, OP_WFLAG: dir_addr_q <= 16'(24'(flag_address_q) & AMASK);
				OP_FILL: dir_addr_q <= 16'(24'(fill_q - CHUNK) & AMASK);
				OP_RREC, OP_WREC: dir_addr_q <= 16'((24'(data_offset_q) + acc_q) & AMASK);
				default: dir_addr_q <= '0;
			endcase
		end
	end

	// percentage select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pct_fix_q <= '0; pmode_q <= '0;
			pct_zero_q <= 1'b0;
		end else begin
			if (mdone_q) begin
				pmode_q   <= phase_q;
				case (phase_q)
					PH_START: pct_fix_q <= 7'd0;
					PH_INIT:  pct_fix_q <= 7'd1;
					PH_WFLAG: pct_fix_q <= 7'd99;
					default:  pct_fix_q <= 7'd100;
				endcase
			end
			if (cmd.pct_start) pct_zero_q <= (pt == 24'd0);
		end
	end

	logic [23:0] qc;
	logic [6:0]  pct_v;
	always_comb begin
		qc = pct_zero_q ? 24'd100 : ((div_q > 24'd100) ? 24'd100 : div_q);
		if (pmode_q == PH_CLEAR) pct_v = (qc + 24'd1 > 24'd98) ? 7'd98 : 7'(qc + 24'd1);
		else if (pmode_q == PH_READ) pct_v = 7'(qc);
		else pct_v = pct_fix_q;
	end

	assign mem_op     = op_q;
	assign mem_addr   = dir_addr_q;
	assign write_dir  = wdir_q;
	assign slot_index = slot_q;
	assign busy_res   = (phase_q != PH_IDLE);
	assign progress   = pct_v;
	logic unused;
	assign unused = ^{rdir_q, sa_flag_q};
endmodule
`default_nettype wire

@@ src/eeprom_wear_level_record_locator.sv @@
`default_nettype none
// Wear-levelled record ring sequencer.
// Channels: req (func, clear_defaults, read_word), rsp (mem_op, mem_addr,
// write_dir, slot_index, busy_res, progress) and cfg (index, data) for the
// five setup registers. Each accepted request gives exactly one response.
// A process step issues one memory request; read data for it comes with the
// next process step.
// A request passes through a slot-count division, an address multiply and a
// percentage division, the two divisions on one shared serial divider, plus
// sequencing. When the progress is a fixed value the percentage division is
// skipped. A new request is taken only once the response has been taken and
// no configuration write is waiting. One request is in flight at a time.
// Reset puts the sequencer at the flag check with default registers.
// If the receiver stalls, the response is held and no request is taken.
// Configuration is taken only while idle with no response pending.
module eeprom_wear_level_record_locator #(
	parameter int FILL_CHUNK = ewl_pkg::FILL_CHUNK_DEF,
	parameter int ADDR_BITS  = ewl_pkg::ADDR_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ewl_in_if.sink   req,
	ewl_out_if.source rsp,
	ewl_cfg_if.sink  cfg
);
	import ewl_pkg::*;

	ewl_cmd_t cmd;
	ewl_sts_t sts;

	ewl_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
		.cmd, .sts
	);

	ewl_dp #(.FILL_CHUNK(FILL_CHUNK), .ADDR_BITS(ADDR_BITS)) u_dp (
		.clk, .arst_n, .cmd, .sts,
		.cfg_index(cfg.index), .cfg_data(cfg.data),
		.func(req.func), .clear_defaults(req.clear_defaults), .read_word(req.read_word),
		.mem_op(rsp.mem_op), .mem_addr(rsp.mem_addr), .write_dir(rsp.write_dir),
		.slot_index(rsp.slot_index), .busy_res(rsp.busy_res), .progress(rsp.progress)
	);
endmodule
`default_nettype wire

@@ tb/ewl_tb_if.sv @@
`timescale 1ns / 100ps
// The block's channel interfaces come with the RTL; the testbench only adds
// packed structs for a request and a response.
package ewl_tb_pkg;
	typedef struct packed {
		logic [2:0]  func;
		logic        clear_defaults;
		logic [15:0] read_word;
	} ewl_request_t;

	typedef struct packed {
		logic [2:0]  mem_op;
		logic [15:0] mem_addr;
		logic        write_dir;
		logic [15:0] slot_index;
		logic        busy_res;
		logic [6:0]  progress;
	} ewl_status_t;
endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
	import ewl_pkg::*;
	import ewl_tb_pkg::*;

	// Tracks the sequencer the way the block should, and checks its responses
	class ring_scoreboard;
		int unsigned mem_bytes, data_offset, record_bytes, flag_address, flag_value;
		phase_t phase;
		bit awaiting_read;
		int unsigned fill_address, slot_pos, s_low, s_mid, s_high;
		bit dir_flag, record_dir;
		ewl_status_t pending[$];
		int mismatches;

		function int unsigned slot_count();
			int unsigned rb, c;
			rb = record_bytes ? record_bytes : 1;
			c = (mem_bytes > data_offset) ? (mem_bytes - data_offset) / rb : 0;
			if (c > 65535) c = 65535;
			if (c == 0) c = 1;
			return c;
		endfunction

		function int unsigned slot_addr(int unsigned pos);
			int unsigned rb;
			rb = record_bytes ? record_bytes : 1;
			return (data_offset + pos * rb) & 16'hFFFF;
		endfunction

		function void search_step(bit up);
			if (up) begin
				s_low = s_mid;
				s_mid = ((s_low + s_high + 1) >> 1) & 16'hFFFF;
			end else begin
				s_high = s_mid;
				s_mid = ((s_low + s_high) >> 1) & 16'hFFFF;
			end
		endfunction

		function void search_begin();
			s_low = 0;
			s_high = (slot_count() - 1) & 16'hFFFF;
			s_mid = 0;
			search_step(1);
		endfunction

		function int unsigned pct(int unsigned part, int unsigned total);
			int unsigned q;
			if (part <= 655) part *= 100;
			else if (part <= 6553) begin
				part *= 10;
				total /= 10;
			end else total /= 100;
			if (total == 0) return 100;
			q = part / total;
			return q > 100 ? 100 : q;
		endfunction

		function int unsigned progress_now();
			int unsigned p, cnt, span;
			case (phase)
				PH_START: return 0;
				PH_INIT: return 1;
				PH_CLEAR: begin
					p = pct(fill_address, mem_bytes) + 1;
					return p > 98 ? 98 : p;
				end
				PH_WFLAG: return 99;
				PH_READ: begin
					cnt = slot_count();
					span = (s_high >= s_low) ? s_high - s_low : 0;
					return pct(cnt > span ? cnt - span : 0, cnt);
				end
				default: return 100;
			endcase
		endfunction

		function void reset_state();
			mem_bytes = 8192; data_offset = 16; record_bytes = 18;
			flag_address = 0; flag_value = 23205;
			phase = PH_START; awaiting_read = 0; fill_address = 0; slot_pos = 0;
			dir_flag = 0; record_dir = 0;
			search_begin();
			pending.delete();
			mismatches = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [16:0] val);
			case (idx)
				REG_MEM_BYTES: mem_bytes = 32'(val);
				REG_DATA_OFFSET: data_offset = 32'(val[15:0]);
				REG_RECORD_BYTES: record_bytes = 32'(val[7:0]);
				REG_FLAG_ADDRESS: flag_address = 32'(val[15:0]);
				REG_FLAG_VALUE: flag_value = 32'(val[15:0]);
				default: ;
			endcase
		endfunction

		// Accepted request: advance the state and queue the expected response
		function void note_request(ewl_request_t r);
			ewl_status_t s;
			bit up;
			s = '0;
			case (r.func)
				FN_LOAD: begin phase = PH_INIT; awaiting_read = 0; end
				FN_SAVE: begin phase = PH_WRITE; awaiting_read = 0; end
				FN_CLEAR: begin
					if (r.clear_defaults) begin dir_flag = 0; record_dir = 0; end
					fill_address = 0; phase = PH_CLEAR; awaiting_read = 0;
				end
				FN_RESTART: begin phase = PH_START; awaiting_read = 0; end
				FN_STEP: begin
					if (awaiting_read) begin
						awaiting_read = 0;
						if (phase == PH_START) begin
							if (r.read_word != flag_value) begin
								phase = PH_CLEAR; fill_address = 0;
							end else phase = PH_INIT;
						end else if (phase == PH_INIT) begin
							record_dir = r.read_word[0];
							dir_flag = record_dir;
							search_begin();
							phase = PH_READ;
						end else if (phase == PH_READ) begin
							record_dir = r.read_word[0];
							up = (dir_flag == record_dir);
							if (s_low == s_high) begin
								slot_pos = s_mid; phase = PH_IDLE;
							end else if (s_mid == s_high && !up) begin
								s_mid = s_low; s_high = s_low;
							end else search_step(up);
						end
					end else begin
						case (phase)
							PH_START: begin
								s.mem_op = OP_RFLAG; s.mem_addr = flag_address[15:0];
								awaiting_read = 1;
							end
							PH_INIT: begin
								s.mem_op = OP_RREC; s.mem_addr = 16'(slot_addr(0));
								awaiting_read = 1;
							end
							PH_READ: begin
								s.mem_op = OP_RREC; s.mem_addr = 16'(slot_addr(s_mid));
								awaiting_read = 1;
							end
							PH_CLEAR: begin
								s.mem_op = OP_FILL; s.mem_addr = fill_address[15:0];
								fill_address += FILL_CHUNK_DEF;
								if (fill_address >= mem_bytes) phase = PH_WFLAG;
								fill_address &= 17'h1FFFF;
							end
							PH_WFLAG: begin
								s.mem_op = OP_WFLAG; s.mem_addr = flag_address[15:0];
								phase = PH_WFIRST;
							end
							PH_WFIRST: begin
								record_dir = 0; dir_flag = 0; slot_pos = 0;
								s.mem_op = OP_WREC; s.mem_addr = 16'(slot_addr(0));
								phase = PH_IDLE;
							end
							PH_WRITE: begin
								if (slot_pos >= slot_count() - 1) begin
									slot_pos = 0; dir_flag ^= 1;
								end else slot_pos = (slot_pos + 1) & 16'hFFFF;
								record_dir = dir_flag;
								s.mem_op = OP_WREC; s.mem_addr = 16'(slot_addr(slot_pos));
								s.write_dir = dir_flag;
								phase = PH_IDLE;
							end
							default: ;
						endcase
					end
				end
				default: ;
			endcase
			s.slot_index = slot_pos[15:0];
			s.busy_res = (phase != PH_IDLE);
			s.progress = 7'(progress_now());
			pending.push_back(s);
		endfunction

		function void check_response(ewl_status_t got);
			ewl_status_t exp;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", got);
				return;
			end
			exp = pending.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	ewl_in_if req();
	ewl_out_if rsp();
	ewl_cfg_if cfg();
	ring_scoreboard sb;
	int src_idle, snk_idle;
	longint cycles;

	eeprom_wear_level_record_locator dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 3000000) begin
				$display("testbench NOT OK");
				$finish;
			end
		end
	end

	// Response side: random stall, check on accept
	initial begin
		rsp.ready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				sb.check_response({rsp.mem_op, rsp.mem_addr, rsp.write_dir,
					rsp.slot_index, rsp.busy_res, rsp.progress});
			@(negedge clk);
			rsp.ready = ($urandom_range(99) >= snk_idle);
		end
	end

	task automatic send_request(logic [2:0] f, logic d, logic [15:0] w);
		ewl_request_t r;
		while ($urandom_range(99) < src_idle) @(negedge clk);
		r = {f, d, w};
		req.valid = 1; req.func = f; req.clear_defaults = d; req.read_word = w;
		do @(posedge clk); while (!req.ready);
		sb.note_request(r);
		@(negedge clk);
		req.valid = 0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (80) @(negedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [16:0] val);
		drain();
		cfg.valid = 1; cfg.index = idx; cfg.data = val;
		do @(posedge clk); while (!cfg.ready);
		sb.write_reg(idx, val);
		@(negedge clk);
		cfg.valid = 0;
	endtask

	// Step with the read data that fits where the predictor stands
	task automatic step_smart(int unsigned newest);
		logic [15:0] w;
		w = $urandom;
		if (sb.awaiting_read) begin
			if (sb.phase == PH_START)
				w = ($urandom_range(3) == 0) ? 16'($urandom) : 16'(sb.flag_value);
			else if (sb.phase == PH_READ)
				w[0] = (sb.s_mid <= newest) ? sb.dir_flag : ~sb.dir_flag;
		end
		send_request(FN_STEP, 1'($urandom_range(1)), w);
	endtask

	task automatic run_until_idle(int unsigned newest, int limit);
		int n;
		n = 0;
		while ((sb.phase != PH_IDLE || sb.awaiting_read) && n < limit) begin
			step_smart(newest);
			n++;
		end
	endtask

	task automatic random_config(bit extreme);
		int unsigned mb, off;
		mb = extreme ? ($urandom_range(1) ? 256 : 65536) : $urandom_range(256, 2048);
		off = ($urandom_range(9) == 0) ? mb + $urandom_range(50) : $urandom_range(mb / 4);
		write_cfg(REG_MEM_BYTES, 17'(mb));
		write_cfg(REG_DATA_OFFSET, 17'(off & 16'hFFFF));
		write_cfg(REG_RECORD_BYTES, extreme ? ($urandom_range(1) ? 17'd1 : 17'd255)
			: 17'($urandom_range(255)));
		write_cfg(REG_FLAG_ADDRESS, 17'($urandom_range(65535)));
		write_cfg(REG_FLAG_VALUE, $urandom_range(1) ? 17'hFFFF : 17'(16'($urandom)));
	endtask

	// Random phase: steps, saves, loads, restarts, clears and noise mixed
	task automatic random_phase(int items);
		int k, c;
		int unsigned newest;
		for (k = 0; k < items; k++) begin
			newest = $urandom_range(sb.slot_count() - 1);
			c = $urandom_range(99);
			if (c < 55) step_smart(newest);
			else if (c < 70) send_request(FN_SAVE, 1'($urandom_range(1)), 16'($urandom));
			else if (c < 78) send_request(FN_LOAD, 1'($urandom_range(1)), 16'($urandom));
			else if (c < 83) send_request(FN_RESTART, 1'($urandom_range(1)), 16'($urandom));
			else if (c < 86 && sb.mem_bytes <= 2048)
				send_request(FN_CLEAR, 1'($urandom_range(1)), 16'($urandom));
			else if (c < 90)
				send_request(3'($urandom_range(5, 7)), 1'($urandom_range(1)), 16'($urandom));
			else send_request(FN_STEP, 1'($urandom_range(1)), 16'($urandom));
			// do not wander into a long fill on a large memory
			if (sb.phase == PH_CLEAR && sb.mem_bytes > 2048)
				send_request(FN_LOAD, 0, 0);
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		src_idle = 0; snk_idle = 0;
		req.valid = 0; req.func = FN_STEP; req.clear_defaults = 0; req.read_word = 0;
		cfg.valid = 0; cfg.index = REG_MEM_BYTES; cfg.data = 0;
		arst_n = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: small memory, wrong flag so format runs through to the end
		write_cfg(REG_MEM_BYTES, 256);
		write_cfg(REG_RECORD_BYTES, 0);
		send_request(FN_STEP, 0, 16'h0000);
		send_request(FN_STEP, 1, 16'hFFFF);
		run_until_idle(0, 40);
		send_request(FN_SAVE, 0, 0);
		send_request(FN_STEP, 0, 0);
		send_request(FN_STEP, 0, 0);
		send_request(3'd7, 1, 16'hFFFF);
		send_request(FN_CLEAR, 1, 0);
		send_request(FN_RESTART, 0, 0);
		send_request(FN_STEP, 0, 0);
		send_request(FN_LOAD, 1, 16'hFFFF);
		// Offset past memory and largest record
		write_cfg(REG_DATA_OFFSET, 16'hFFFF);
		write_cfg(REG_RECORD_BYTES, 255);
		send_request(FN_LOAD, 0, 0);
		run_until_idle(0, 40);
		send_request(FN_SAVE, 0, 0);
		send_request(FN_STEP, 0, 0);

		// Random phases with three idling profiles, configs in between
		for (int ph = 0; ph < 9; ph++) begin
			src_idle = (ph < 3) ? 25 : (ph < 6) ? 80 : 0;
			snk_idle = (ph < 3) ? 80 : (ph < 6) ? 25 : 0;
			random_config(ph % 3 == 0);
			send_request(FN_LOAD, 0, 0);
			random_phase(200);
			if (ph == 4) drain();
		end

		while (sb.pending.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule

@@ filelist.f @@
+incdir+src
src/ewl_pkg.sv
src/ewl_if.sv
src/ewl_div.sv
src/ewl_ctrl.sv
src/ewl_dp.sv
src/eeprom_wear_level_record_locator.sv
tb/ewl_tb_if.sv
tb/testbench.sv
